FILE: hw/rtl/ssqi_pkg.sv
// shared widths, types and constants of the quasi-invariant pipeline
package ssqi_pkg;

   localparam int COLOR_W      = 16;
   localparam int DERIV_W      = 18;
   localparam int OUT_W        = 32;
   localparam int FRAC_DEFAULT = 16;

   localparam int LANES        = 6;
   localparam int CHANNELS     = 3;

   localparam int PRE_BITS     = 8;
   localparam int SQRT_BITS    = 14;

   localparam int SUM_W        = 34;
   localparam int DOT_W        = 36;
   localparam int PP_W         = 36;
   localparam int NUM_W        = 54;
   localparam int MAG_W        = NUM_W - 1;
   localparam int S_SPLIT      = 17;
   localparam int DOT_SPLIT    = 18;

   localparam int DVD_W        = 62;
   localparam int P_W          = 27;
   localparam int SQRT_IN_W    = 62;
   localparam int ROOT_W       = SQRT_IN_W / 2;
   localparam int DVD2_W       = 63;
   localparam int QUO_W        = OUT_W - 1;

   localparam int FRONT_STAGES = 6;

   localparam logic signed [OUT_W-1:0] RES_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] RES_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef logic        [COLOR_W-1:0] color_type;
   typedef logic signed [DERIV_W-1:0] deriv_type;
   typedef logic        [SUM_W-1:0]   sum_type;
   typedef logic        [DVD_W-1:0]   dvd_type;
   typedef logic        [P_W-1:0]     pmag_type;
   typedef logic        [ROOT_W-1:0]  root_type;
   typedef logic        [QUO_W-1:0]   quo_type;
   typedef logic signed [OUT_W-1:0]   res_type;

endpackage

FILE: hw/rtl/ssqi_delay.sv
// pipelined delay line that keeps side data level with the arithmetic
module ssqi_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] en,
   input  logic [W-1:0]     din,
   output logic [W-1:0]     dout
);
   logic [W-1:0] tap_ff [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tap
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en[k]) begin
               tap_ff[k] <= din;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en[k]) begin
               tap_ff[k] <= tap_ff[k-1];
            end
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

FILE: hw/rtl/ssqi_div.sv
// restoring divider, one quotient bit per pipeline stage
module ssqi_div #(
   parameter int NUM_W = 62,
   parameter int DEN_W = 34,
   parameter int QW    = 27
) (
   input  logic             clock,
   input  logic [QW-1:0]    en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QW-1:0]    quo
);
   logic [NUM_W-1:0] rem_ff [QW-1];
   logic [DEN_W-1:0] den_ff [QW-1];
   logic [QW-1:0]    q_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [NUM_W-1:0] rem_prev;
      logic [NUM_W-1:0] trial;
      logic [DEN_W-1:0] den_prev;
      logic [QW-1:0]    q_prev;
      logic             fit;

      if (k == 0) begin : g_src_in
         assign rem_prev = num;
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_src_prev
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      // divisor lined up with the current quotient bit
      assign trial = NUM_W'(den_prev) << (QW - 1 - k);
      assign fit   = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (en[k]) begin
            q_ff[k] <= {q_prev[QW-2:0], fit};
         end
      end

      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k] <= fit ? (rem_prev - trial) : rem_prev;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quo = q_ff[QW-1];
endmodule

FILE: hw/rtl/ssqi_sqrt.sv
// digit-by-digit integer square root, one root bit per pipeline stage
module ssqi_sqrt #(
   parameter int IN_W = 62
) (
   input  logic               clock,
   input  logic [IN_W/2-1:0]  en,
   input  logic [IN_W-1:0]    radicand,
   output logic [IN_W/2-1:0]  root
);
   localparam int STEPS = IN_W / 2;
   localparam int REM_W = IN_W + 1;

   logic [REM_W-1:0] rem_ff  [STEPS-1];
   logic [STEPS-1:0] root_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int B = STEPS - 1 - k;
      logic [REM_W-1:0] rem_prev;
      logic [REM_W-1:0] trial;
      logic [STEPS-1:0] root_prev;
      logic             fit;

      if (k == 0) begin : g_src_in
         assign rem_prev  = REM_W'(radicand);
         assign root_prev = '0;
      end else begin : g_src_prev
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      assign trial = (REM_W'(root_prev) << (B + 1)) + (REM_W'(1) << (2 * B));
      assign fit   = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (en[k]) begin
            root_ff[k] <= root_prev | (STEPS'(fit) << B);
         end
      end

      if (k < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k] <= fit ? (rem_prev - trial) : rem_prev;
            end
         end
      end
   end

   assign root = root_ff[STEPS-1];
endmodule

FILE: hw/rtl/ssqi_front.sv
// front end: squared norm, dot products and projection remainders
module ssqi_front (
   input  logic                                  clock,
   input  logic [ssqi_pkg::FRONT_STAGES-1:0]     en,
   input  ssqi_pkg::color_type                   color    [ssqi_pkg::CHANNELS],
   input  ssqi_pkg::deriv_type                   deriv    [ssqi_pkg::LANES],
   output ssqi_pkg::dvd_type                     dividend [ssqi_pkg::LANES],
   output logic [ssqi_pkg::LANES-1:0]            neg,
   output ssqi_pkg::sum_type                     sum_sq,
   output logic                                  zero
);
   import ssqi_pkg::*;

   // stage 1: squares and derivative-colour products
   color_type                c1_ff   [CHANNELS];
   logic [2*COLOR_W-1:0]     sq1_ff  [CHANNELS];
   deriv_type                d1_ff   [LANES];
   logic signed [DERIV_W+COLOR_W:0] dc1_ff [LANES];
   // stage 2: sums
   color_type                c2_ff   [CHANNELS];
   deriv_type                d2_ff   [LANES];
   sum_type                  s2_ff;
   logic signed [DOT_W-1:0]  dot2_ff [2];
   // stage 3: partial products
   sum_type                  s3_ff;
   logic signed [PP_W-1:0]   plo3_ff [LANES];
   logic signed [PP_W-1:0]   phi3_ff [LANES];
   logic signed [PP_W-1:0]   clo3_ff [LANES];
   logic signed [PP_W-1:0]   chi3_ff [LANES];
   // stage 4: full products
   sum_type                  s4_ff;
   logic signed [NUM_W-1:0]  a4_ff   [LANES];
   logic signed [NUM_W-1:0]  b4_ff   [LANES];
   // stage 5: numerator
   sum_type                  s5_ff;
   logic signed [NUM_W-1:0]  num5_ff [LANES];
   // stage 6: magnitude and sign
   dvd_type                  dvd_ff  [LANES];
   logic [LANES-1:0]         neg_ff;
   sum_type                  sum_ff;
   logic                     zero_ff;

   logic [MAG_W-1:0]         mag     [LANES];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < CHANNELS; i++) begin
            c1_ff[i]  <= color[i];
            sq1_ff[i] <= color[i] * color[i];
         end
         for (int l = 0; l < LANES; l++) begin
            d1_ff[l]  <= deriv[l];
            dc1_ff[l] <= deriv[l] * $signed({1'b0, color[l % CHANNELS]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c2_ff <= c1_ff;
         d2_ff <= d1_ff;
         s2_ff <= SUM_W'(sq1_ff[0]) + SUM_W'(sq1_ff[1]) + SUM_W'(sq1_ff[2]);
         for (int j = 0; j < 2; j++) begin
            dot2_ff[j] <= DOT_W'(dc1_ff[CHANNELS*j]) + DOT_W'(dc1_ff[CHANNELS*j+1])
                        + DOT_W'(dc1_ff[CHANNELS*j+2]);
         end
      end
   end

   // norm and dot product split in halves to keep each multiplier narrow
   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_ff <= s2_ff;
         for (int l = 0; l < LANES; l++) begin
            plo3_ff[l] <= d2_ff[l] * $signed({1'b0, s2_ff[S_SPLIT-1:0]});
            phi3_ff[l] <= d2_ff[l] * $signed({1'b0, s2_ff[SUM_W-1:S_SPLIT]});
            clo3_ff[l] <= $signed({1'b0, c2_ff[l % CHANNELS]})
                        * $signed({1'b0, dot2_ff[l / CHANNELS][DOT_SPLIT-1:0]});
            chi3_ff[l] <= $signed({1'b0, c2_ff[l % CHANNELS]})
                        * $signed(dot2_ff[l / CHANNELS][DOT_W-1:DOT_SPLIT]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_ff <= s3_ff;
         for (int l = 0; l < LANES; l++) begin
            a4_ff[l] <= (NUM_W'(phi3_ff[l]) <<< S_SPLIT) + NUM_W'(plo3_ff[l]);
            b4_ff[l] <= (NUM_W'(chi3_ff[l]) <<< DOT_SPLIT) + NUM_W'(clo3_ff[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_ff <= s4_ff;
         for (int l = 0; l < LANES; l++) begin
            num5_ff[l] <= a4_ff[l] - b4_ff[l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag[l] = num5_ff[l][NUM_W-1] ? MAG_W'(-num5_ff[l]) : MAG_W'(num5_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         sum_ff  <= s5_ff;
         zero_ff <= (s5_ff == '0);
         for (int l = 0; l < LANES; l++) begin
            neg_ff[l] <= num5_ff[l][NUM_W-1];
            dvd_ff[l] <= DVD_W'(mag[l]) << PRE_BITS;
         end
      end
   end

   assign dividend = dvd_ff;
   assign neg      = neg_ff;
   assign sum_sq   = sum_ff;
   assign zero     = zero_ff;
endmodule

FILE: hw/rtl/shadow_shading_quasi_invariant.sv
// top level of the shadow-shading quasi-invariant pipeline
//
// Takes one pixel per clock: an RGB colour (unsigned Q0.16) and its x and y
// derivatives (signed Q1.16), and returns for each derivative the part that
// lies across the colour direction, divided by the colour norm, as signed
// Q(31-FRAC_BITS).FRAC_BITS values saturated to 32 bits. A black pixel gives
// all-zero outputs with zero_norm set. The block is a 70-stage pipeline: six
// front stages build the norm, dot products and remainders, a 27-stage
// restoring divider per lane removes the squared norm while a 31-stage
// square root runs alongside, one stage checks for saturation and a 31-stage
// divider per lane applies the reciprocal norm, then an output register.
// One item can be accepted every cycle while req_stall is low. Each stage
// holds its item only while every stage downstream of it is full and the
// output is stalled, so bubbles close up and an item is still taken while a
// finished result waits at the output.
module shadow_shading_quasi_invariant #(
   parameter int FRAC_BITS = ssqi_pkg::FRAC_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ssqi_pkg::color_type         req_red,
   input  ssqi_pkg::color_type         req_green,
   input  ssqi_pkg::color_type         req_blue,
   input  ssqi_pkg::deriv_type         req_dx_red,
   input  ssqi_pkg::deriv_type         req_dx_green,
   input  ssqi_pkg::deriv_type         req_dx_blue,
   input  ssqi_pkg::deriv_type         req_dy_red,
   input  ssqi_pkg::deriv_type         req_dy_green,
   input  ssqi_pkg::deriv_type         req_dy_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ssqi_pkg::res_type           rsp_inv_x_red,
   output ssqi_pkg::res_type           rsp_inv_x_green,
   output ssqi_pkg::res_type           rsp_inv_x_blue,
   output ssqi_pkg::res_type           rsp_inv_y_red,
   output ssqi_pkg::res_type           rsp_inv_y_green,
   output ssqi_pkg::res_type           rsp_inv_y_blue,
   output logic                        rsp_zero_norm
);
   import ssqi_pkg::*;

   // stage map
   localparam int DIV1_FIRST = FRONT_STAGES;
   localparam int DIV1_LAST  = DIV1_FIRST + P_W - 1;
   localparam int SQRT_LAST  = DIV1_FIRST + ROOT_W - 1;
   localparam int PDLY_FIRST = DIV1_LAST + 1;
   localparam int PDLY_DEPTH = SQRT_LAST - DIV1_LAST;
   localparam int OVF_STAGE  = SQRT_LAST + 1;
   localparam int DIV2_FIRST = OVF_STAGE + 1;
   localparam int DIV2_LAST  = DIV2_FIRST + QUO_W - 1;
   localparam int SIDE_DEPTH = DIV2_LAST - DIV1_FIRST + 1;
   localparam int OUT_STAGE  = DIV2_LAST + 1;
   localparam int STAGES     = OUT_STAGE + 1;

   // reciprocal-norm scaling: Q.24 remainder over a Q.14 norm
   localparam int N_SHIFT    = FRAC_BITS + SQRT_BITS - PRE_BITS;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES-1:0] go;

   color_type         color_in [CHANNELS];
   deriv_type         deriv_in [LANES];

   dvd_type           dividend [LANES];
   logic [LANES-1:0]  neg;
   sum_type           sum_sq;
   logic              zero;

   pmag_type          pmag     [LANES];
   pmag_type          pmag_d   [LANES];
   root_type          root;

   logic [DVD2_W-1:0] n_in     [LANES];
   logic [DVD2_W-1:0] lim;
   logic [DVD2_W-1:0] n_ff     [LANES];
   root_type          q_ff;
   logic [LANES-1:0]  ovf_ff;

   quo_type           quo      [LANES];
   logic [LANES:0]    side_d;
   logic [LANES-1:0]  ovf_d;

   res_type           res_in   [LANES];
   res_type           res_ff   [LANES];
   logic              zero_ff;

   // a stage moves on when the output is free or a bubble lies ahead of it
   for (genvar i = 0; i < STAGES; i++) begin : g_go
      assign go[i] = ~rsp_stall | ~(&v_ff[STAGES-1:i]);
   end

   assign v_in      = {v_ff[STAGES-2:0], req_valid};
   assign req_stall = ~go[0];
   assign rsp_valid = v_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (go[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign color_in[0] = req_red;
   assign color_in[1] = req_green;
   assign color_in[2] = req_blue;
   assign deriv_in[0] = req_dx_red;
   assign deriv_in[1] = req_dx_green;
   assign deriv_in[2] = req_dx_blue;
   assign deriv_in[3] = req_dy_red;
   assign deriv_in[4] = req_dy_green;
   assign deriv_in[5] = req_dy_blue;

   ssqi_front u_front (
      .clock    (clock),
      .en       (go[FRONT_STAGES-1:0]),
      .color    (color_in),
      .deriv    (deriv_in),
      .dividend (dividend),
      .neg      (neg),
      .sum_sq   (sum_sq),
      .zero     (zero)
   );

   // colour norm with 14 fraction bits, in parallel with the first divide
   ssqi_sqrt #(
      .IN_W (SQRT_IN_W)
   ) u_sqrt (
      .clock    (clock),
      .en       (go[SQRT_LAST:DIV1_FIRST]),
      .radicand (SQRT_IN_W'(sum_sq) << (2 * SQRT_BITS)),
      .root     (root)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      // remainder over squared norm, magnitude in Q.24
      ssqi_div #(
         .NUM_W (DVD_W),
         .DEN_W (SUM_W),
         .QW    (P_W)
      ) u_div_proj (
         .clock (clock),
         .en    (go[DIV1_LAST:DIV1_FIRST]),
         .num   (dividend[l]),
         .den   (sum_sq),
         .quo   (pmag[l])
      );

      // wait for the square root to finish
      ssqi_delay #(
         .W     (P_W),
         .DEPTH (PDLY_DEPTH)
      ) u_pdly (
         .clock (clock),
         .en    (go[SQRT_LAST:PDLY_FIRST]),
         .din   (pmag[l]),
         .dout  (pmag_d[l])
      );

      assign n_in[l] = DVD2_W'(pmag_d[l]) << N_SHIFT;

      // quotient bits beyond 31 only decide saturation
      ssqi_div #(
         .NUM_W (DVD2_W),
         .DEN_W (ROOT_W),
         .QW    (QUO_W)
      ) u_div_norm (
         .clock (clock),
         .en    (go[DIV2_LAST:DIV2_FIRST]),
         .num   (n_ff[l]),
         .den   (q_ff),
         .quo   (quo[l])
      );
   end

   assign lim = DVD2_W'(root) << QUO_W;

   always_ff @(posedge clock) begin
      if (go[OVF_STAGE]) begin
         q_ff <= root;
         for (int l = 0; l < LANES; l++) begin
            n_ff[l]   <= n_in[l];
            ovf_ff[l] <= (n_in[l] >= lim);
         end
      end
   end

   // sign and black-pixel flag ride alongside both dividers
   ssqi_delay #(
      .W     (LANES + 1),
      .DEPTH (SIDE_DEPTH)
   ) u_side_dly (
      .clock (clock),
      .en    (go[DIV2_LAST:DIV1_FIRST]),
      .din   ({zero, neg}),
      .dout  (side_d)
   );

   ssqi_delay #(
      .W     (LANES),
      .DEPTH (QUO_W)
   ) u_ovf_dly (
      .clock (clock),
      .en    (go[DIV2_LAST:DIV2_FIRST]),
      .din   (ovf_ff),
      .dout  (ovf_d)
   );

   // sign restore, saturation and black-pixel forcing
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (side_d[LANES]) begin
            res_in[l] = '0;
         end else if (ovf_d[l]) begin
            res_in[l] = side_d[l] ? RES_MIN : RES_MAX;
         end else if (side_d[l]) begin
            res_in[l] = -$signed({1'b0, quo[l]});
         end else begin
            res_in[l] = $signed({1'b0, quo[l]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[OUT_STAGE]) begin
         res_ff  <= res_in;
         zero_ff <= side_d[LANES];
      end
   end

   assign rsp_inv_x_red   = res_ff[0];
   assign rsp_inv_x_green = res_ff[1];
   assign rsp_inv_x_blue  = res_ff[2];
   assign rsp_inv_y_red   = res_ff[3];
   assign rsp_inv_y_green = res_ff[4];
   assign rsp_inv_y_blue  = res_ff[5];
   assign rsp_zero_norm   = zero_ff;
endmodule

FILE: bench/shadow_shading_quasi_invariant_tb.sv
// self-checking testbench of the shadow-shading quasi-invariant pipeline
module shadow_shading_quasi_invariant_tb;
   import ssqi_pkg::*;

   localparam int FRAC = FRAC_DEFAULT;
   localparam int LATENCY = 70;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   // one pixel and the invariant it should give
   typedef struct {
      color_type c[3];
      deriv_type dx[3];
      deriv_type dy[3];
   } pixel_type;

   typedef struct {
      res_type ix[3];
      res_type iy[3];
      logic    zero;
   } invariant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   color_type req_red = '0, req_green = '0, req_blue = '0;
   deriv_type req_dx_red = '0, req_dx_green = '0, req_dx_blue = '0;
   deriv_type req_dy_red = '0, req_dy_green = '0, req_dy_blue = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   res_type rsp_inv_x_red, rsp_inv_x_green, rsp_inv_x_blue;
   res_type rsp_inv_y_red, rsp_inv_y_green, rsp_inv_y_blue;
   logic rsp_zero_norm;

   invariant_type expected_invariants[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   int  hold_count = 0;
   bit  hold_output = 1'b0;  // long receiver hold-off in progress
   bit  random_stall = 1'b1;

   shadow_shading_quasi_invariant #(.FRAC_BITS(FRAC)) dut (.*);

   always #10 clock = ~clock;

   // integer square root, bit by bit
   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic res_type saturate(longint v);
      if (v > 64'sd2147483647) return RES_MAX;
      if (v < -64'sd2147483648) return RES_MIN;
      return res_type'(v);
   endfunction

   // remainder across the colour direction, scaled by the reciprocal norm
   function automatic void project_out(input longint c[3], input deriv_type d[3],
                                       input longint s, input longint q,
                                       output res_type r[3]);
      longint dv[3];
      longint dot, num, p;
      for (int i = 0; i < 3; i++) dv[i] = longint'(d[i]);
      dot = dv[0]*c[0] + dv[1]*c[1] + dv[2]*c[2];
      for (int i = 0; i < 3; i++) begin
         num = dv[i]*s - c[i]*dot;
         p = (num * (64'sd1 << PRE_BITS)) / s;
         r[i] = saturate((p * (64'sd1 << (FRAC + SQRT_BITS - PRE_BITS))) / q);
      end
   endfunction

   function automatic invariant_type predict_invariant(pixel_type px);
      invariant_type e;
      longint c[3];
      longint s, q;
      for (int i = 0; i < 3; i++) c[i] = longint'({1'b0, px.c[i]});
      s = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
      e.zero = (s == 0);
      if (s == 0) begin
         for (int i = 0; i < 3; i++) begin
            e.ix[i] = '0;
            e.iy[i] = '0;
         end
      end else begin
         q = longint'(root_of(longint'(unsigned'(s)) << (2*SQRT_BITS)));
         project_out(c, px.dx, s, q, e.ix);
         project_out(c, px.dy, s, q, e.iy);
      end
      return e;
   endfunction

   // sender side: offer one pixel, after a random gap if gaps is set, wait for acceptance
   task automatic send_pixel(pixel_type px, bit gaps = 1'b1);
      int gap;
      if (gaps) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
               ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_red      <= px.c[0];
      req_green    <= px.c[1];
      req_blue     <= px.c[2];
      req_dx_red   <= px.dx[0];
      req_dx_green <= px.dx[1];
      req_dx_blue  <= px.dx[2];
      req_dy_red   <= px.dy[0];
      req_dy_green <= px.dy[1];
      req_dy_blue  <= px.dy[2];
      do @(posedge clock); while (req_stall);
      expected_invariants.push_back(predict_invariant(px));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic deriv_type random_deriv();
      case ($urandom_range(0, 5))
         0: return deriv_type'(65536);
         1: return deriv_type'(-65536);
         2: return deriv_type'($urandom);  // any 18-bit pattern
         default: return deriv_type'(int'($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         case (mode)
            0: px.c[i] = color_type'($urandom_range(0, 3));     // very dark
            1: px.c[i] = color_type'($urandom_range(0, 255));
            2: px.c[i] = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
            default: px.c[i] = color_type'($urandom);
         endcase
         px.dx[i] = random_deriv();
         px.dy[i] = random_deriv();
      end
      if (mode == 3) px.c = '{16'h0, 16'h0, 16'h0};             // black pixel
      return px;
   endfunction

   function automatic pixel_type make_pixel(int r, int g, int b, int dx, int dy);
      pixel_type px;
      px.c = '{color_type'(r), color_type'(g), color_type'(b)};
      px.dx = '{deriv_type'(dx), deriv_type'(-dx), deriv_type'(dx)};
      px.dy = '{deriv_type'(dy), deriv_type'(dy), deriv_type'(-dy)};
      return px;
   endfunction

   // extremes of colour and derivative, black pixels, saturation, odd patterns
   task automatic test_directed();
      pixel_type px;
      send_pixel(make_pixel(0, 0, 0, 65536, -65536));
      send_pixel(make_pixel(65535, 65535, 65535, 65536, -65536));
      send_pixel(make_pixel(65535, 65535, 65535, -65536, 65536));
      send_pixel(make_pixel(1, 0, 0, 65536, -65536));           // saturates
      send_pixel(make_pixel(0, 1, 0, -65536, 65536));
      send_pixel(make_pixel(0, 0, 1, 65536, 65536));
      send_pixel(make_pixel(1, 1, 1, -65536, -65536));
      send_pixel(make_pixel(65535, 0, 0, 65536, 0));
      send_pixel(make_pixel(0, 65535, 0, 0, 65536));
      send_pixel(make_pixel(0, 0, 65535, 1, -1));
      send_pixel(make_pixel(32768, 16384, 1, 0, 0));
      send_pixel(make_pixel(0, 0, 0, 0, 0));
      // derivative along the colour: remainder vanishes
      px = make_pixel(1000, 2000, 3000, 0, 0);
      px.dx = '{deriv_type'(1000), deriv_type'(2000), deriv_type'(3000)};
      send_pixel(px);
      // all-ones and top-bit derivative patterns, some outside the nominal range
      px = make_pixel(12345, 54321, 777, 0, 0);
      px.dx = '{18'h3FFFF, 18'h20000, 18'h1FFFF};
      px.dy = '{18'h20000, 18'h1FFFF, 18'h3FFFF};
      send_pixel(px);
      px = make_pixel(2, 3, 0, 0, 0);
      px.dx = '{18'h1FFFF, 18'h20000, 18'h2AAAA};
      px.dy = '{18'h15555, 18'h3FFFF, 18'h00001};
      send_pixel(px);
      end_burst();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) send_pixel(random_pixel());
      end_burst();
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_backpressure();
      hold_output = 1'b1;
      for (int n = 0; n < 150; n++) send_pixel(random_pixel(), 1'b0);
      end_burst();
      wait (hold_output == 1'b0);
   endtask

   // sender waits for every expected result, or until the guard runs out, before going on
   task automatic drain_pipeline();
      int guard;
      guard = 0;
      while (expected_invariants.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // full rate with the output never stalled
   task automatic test_streaming();
      random_stall = 1'b0;
      for (int n = 0; n < 200; n++) send_pixel(random_pixel(), 1'b0);
      end_burst();
      drain_pipeline();
      random_stall = 1'b1;
   endtask

   // receiver stall pattern; the long hold-off is counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else if (hold_output) begin
         if (hold_count >= HOLD_CYCLES) begin
            hold_output = 1'b0;
            hold_count <= 0;
            rsp_stall <= 1'b0;
         end else begin
            hold_count <= hold_count + 1;
            rsp_stall <= 1'b1;
         end
      end else if (!random_stall) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0) ||
                      ($urandom_range(0, 60) == 0 && rsp_stall);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      invariant_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_invariants.size() == 0) begin
               $error("result with no expectation waiting");
               fail_count++;
            end else begin
               e = expected_invariants.pop_front();
               if (rsp_inv_x_red !== e.ix[0]) begin
                  $error("inv_x_red exp %0d got %0d", e.ix[0], rsp_inv_x_red);
                  fail_count++;
               end
               if (rsp_inv_x_green !== e.ix[1]) begin
                  $error("inv_x_green exp %0d got %0d", e.ix[1], rsp_inv_x_green);
                  fail_count++;
               end
               if (rsp_inv_x_blue !== e.ix[2]) begin
                  $error("inv_x_blue exp %0d got %0d", e.ix[2], rsp_inv_x_blue);
                  fail_count++;
               end
               if (rsp_inv_y_red !== e.iy[0]) begin
                  $error("inv_y_red exp %0d got %0d", e.iy[0], rsp_inv_y_red);
                  fail_count++;
               end
               if (rsp_inv_y_green !== e.iy[1]) begin
                  $error("inv_y_green exp %0d got %0d", e.iy[1], rsp_inv_y_green);
                  fail_count++;
               end
               if (rsp_inv_y_blue !== e.iy[2]) begin
                  $error("inv_y_blue exp %0d got %0d", e.iy[2], rsp_inv_y_blue);
                  fail_count++;
               end
               if (rsp_zero_norm !== e.zero) begin
                  $error("zero_norm exp %0b got %0b", e.zero, rsp_zero_norm);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(800);
      test_backpressure();
      drain_pipeline();
      test_streaming();
      test_random(850);
      drain_pipeline();
      repeat (LATENCY + 10) @(posedge clock);
      if (expected_invariants.size() != 0) begin
         $error("%0d expected results never arrived", expected_invariants.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
